@@ sv/hcpe_pkg.sv @@
// Shared types and constants of the Hermite curve point evaluator.
package hcpe_pkg;

	// Pipeline depth from input register to output register.
	localparam int NUM_STAGES = 7;

	// Fixed widths of the window registers and the pixel outputs.
	localparam int WIN_BITS = 13;
	localparam int OUT_BITS = 14;
	localparam int OUT_MIN  = -8192;
	localparam int OUT_MAX  = 8191;

	// Configuration port.
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;
	localparam logic [WIN_BITS-1:0]     WIN_RESET  = 13'd700;

	// Load enables, one per pipeline stage.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} pipe_en_t;

endpackage

@@ sv/hcpe_power.sv @@
// Powers of t shared by both lanes: saturated t, t squared and t cubed.
module hcpe_power #(
	parameter int T_FRAC_BITS = 16
) (
	input  logic                   clk,
	input  hcpe_pkg::pipe_en_t     en,
	input  logic [T_FRAC_BITS:0]   t_fraction,
	output logic [T_FRAC_BITS:0]   a_s3,
	output logic [T_FRAC_BITS:0]   t2_s3,
	output logic [T_FRAC_BITS:0]   t3_s3
);

	localparam int F  = T_FRAC_BITS;
	localparam int PW = 2 * F + 2;

	logic [F:0]    a_sat;
	logic [F:0]    a_s1, a_s2;
	logic [F:0]    t2_s2;
	logic [PW-1:0] sq, cube;

	// anything above one clamps to exactly one
	assign a_sat = (t_fraction[F] && (|t_fraction[F-1:0])) ?
		{1'b1, {F{1'b0}}} : t_fraction;

	assign sq   = PW'(a_s1) * PW'(a_s1);
	assign cube = PW'(t2_s2) * PW'(a_s2);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			a_s1 <= a_sat;
		end
		if (en.s2) begin
			a_s2  <= a_s1;
			t2_s2 <= sq[2*F:F];
		end
		if (en.s3) begin
			a_s3  <= a_s2;
			t2_s3 <= t2_s2;
			t3_s3 <= cube[2*F:F];
		end
	end

endmodule

@@ sv/hcpe_lane.sv @@
// One coordinate lane: cubic coefficients, products, sum and truncation.
module hcpe_lane #(
	parameter int T_FRAC_BITS = 16,
	parameter int COORD_BITS  = 12
) (
	input  logic                                     clk,
	input  hcpe_pkg::pipe_en_t                       en,
	input  logic [COORD_BITS-1:0]                    q0,
	input  logic [COORD_BITS-1:0]                    q1,
	input  logic [COORD_BITS-1:0]                    q2,
	input  logic [COORD_BITS-1:0]                    q3,
	input  logic [T_FRAC_BITS:0]                     a_s3,
	input  logic [T_FRAC_BITS:0]                     t2_s3,
	input  logic [T_FRAC_BITS:0]                     t3_s3,
	output logic signed [COORD_BITS+6:0]             coord_s6
);

	localparam int F   = T_FRAC_BITS;
	localparam int C   = COORD_BITS;
	localparam int CFW = C + 4;
	localparam int PW  = CFW + F + 2;
	localparam int SW  = C + F + 7;

	localparam logic signed [CFW-1:0] K2 = CFW'(2);
	localparam logic signed [CFW-1:0] K3 = CFW'(3);

	logic signed [CFW-1:0] e0, e1, e2, e3;
	logic signed [CFW-1:0] v_c, w_c, c2_c, c3_c;

	logic [C-1:0]          q1_s1, q1_s2, q1_s3, q1_s4;
	logic signed [CFW-1:0] v_s1, c2_s1, c3_s1;
	logic signed [CFW-1:0] v_s2, c2_s2, c3_s2;
	logic signed [CFW-1:0] v_s3, c2_s3, c3_s3;

	logic signed [PW-1:0]  v_x, c2_x, c3_x, a_x, t2_x, t3_x;
	logic signed [PW-1:0]  pv_s4, p2_s4, p3_s4;
	logic signed [SW-1:0]  pv_w, p2_w, p3_w, base_w;
	logic signed [SW-1:0]  sum_s5, biased;

	assign e0 = signed'({4'b0, q0});
	assign e1 = signed'({4'b0, q1});
	assign e2 = signed'({4'b0, q2});
	assign e3 = signed'({4'b0, q3});

	// tangents and cubic coefficients
	assign v_c  = e1 - e0;
	assign w_c  = e3 - e2;
	assign c2_c = K3 * (e2 - e1) - K2 * v_c - w_c;
	assign c3_c = K2 * (e1 - e2) + v_c + w_c;

	// sign-extend coefficients, zero-extend the powers of t
	assign v_x  = PW'(v_s3);
	assign c2_x = PW'(c2_s3);
	assign c3_x = PW'(c3_s3);
	assign a_x  = signed'(PW'(a_s3));
	assign t2_x = signed'(PW'(t2_s3));
	assign t3_x = signed'(PW'(t3_s3));

	assign pv_w   = SW'(pv_s4);
	assign p2_w   = SW'(p2_s4);
	assign p3_w   = SW'(p3_s4);
	assign base_w = signed'(SW'({q1_s4, {F{1'b0}}}));

	// truncate toward zero: bias negatives before the shift
	assign biased = sum_s5 + (sum_s5[SW-1] ? signed'(SW'({F{1'b1}})) : signed'(SW'(0)));

	always_ff @(posedge clk) begin
		if (en.s1) begin
			q1_s1 <= q1;
			v_s1  <= v_c;
			c2_s1 <= c2_c;
			c3_s1 <= c3_c;
		end
		if (en.s2) begin
			q1_s2 <= q1_s1;
			v_s2  <= v_s1;
			c2_s2 <= c2_s1;
			c3_s2 <= c3_s1;
		end
		if (en.s3) begin
			q1_s3 <= q1_s2;
			v_s3  <= v_s2;
			c2_s3 <= c2_s2;
			c3_s3 <= c3_s2;
		end
		if (en.s4) begin
			q1_s4 <= q1_s3;
			pv_s4 <= v_x * a_x;
			p2_s4 <= c2_x * t2_x;
			p3_s4 <= c3_x * t3_x;
		end
		if (en.s5) begin
			sum_s5 <= base_w + pv_w + p2_w + p3_w;
		end
		if (en.s6) begin
			coord_s6 <= biased[SW-1:F];
		end
	end

endmodule

@@ sv/hcpe_merge.sv @@
// Merge stage: output saturation and the in-window flag for both lanes.
module hcpe_merge #(
	parameter int COORD_W = 19
) (
	input  logic                                    clk,
	input  hcpe_pkg::pipe_en_t                      en,
	input  logic signed [COORD_W-1:0]               x_s6,
	input  logic signed [COORD_W-1:0]               y_s6,
	input  logic [hcpe_pkg::WIN_BITS-1:0]           win_width,
	input  logic [hcpe_pkg::WIN_BITS-1:0]           win_height,
	output logic signed [hcpe_pkg::OUT_BITS-1:0]    pixel_x,
	output logic signed [hcpe_pkg::OUT_BITS-1:0]    pixel_y,
	output logic                                    in_window
);

	localparam logic signed [COORD_W-1:0] LO = COORD_W'(hcpe_pkg::OUT_MIN);
	localparam logic signed [COORD_W-1:0] HI = COORD_W'(hcpe_pkg::OUT_MAX);

	logic signed [COORD_W-1:0]            wx, wy;
	logic signed [hcpe_pkg::OUT_BITS-1:0] cx, cy;
	logic                                 win_hit;

	assign wx = signed'(COORD_W'(win_width));
	assign wy = signed'(COORD_W'(win_height));

	always_comb begin
		priority if (x_s6 < LO) cx = hcpe_pkg::OUT_BITS'(hcpe_pkg::OUT_MIN);
		else if (x_s6 > HI)     cx = hcpe_pkg::OUT_BITS'(hcpe_pkg::OUT_MAX);
		else                    cx = x_s6[hcpe_pkg::OUT_BITS-1:0];
		priority if (y_s6 < LO) cy = hcpe_pkg::OUT_BITS'(hcpe_pkg::OUT_MIN);
		else if (y_s6 > HI)     cy = hcpe_pkg::OUT_BITS'(hcpe_pkg::OUT_MAX);
		else                    cy = y_s6[hcpe_pkg::OUT_BITS-1:0];
	end

	// judged on the unsaturated coordinates
	assign win_hit = !x_s6[COORD_W-1] && !y_s6[COORD_W-1] && (x_s6 < wx) && (y_s6 < wy);

	always_ff @(posedge clk) begin
		if (en.s7) begin
			pixel_x   <= cx;
			pixel_y   <= cy;
			in_window <= win_hit;
		end
	end

endmodule

@@ sv/hermite_curve_point_eval.sv @@
// Top level of the Hermite curve point evaluator: handshake, registers, lanes.
//
// Evaluates one point of a cubic Hermite curve per transfer. Each input transfer carries
// control points P0..P3 and a parameter t (unsigned, T_FRAC_BITS fraction bits, values
// above one clamp to one); the curve runs from P1 to P2 with tangents P1-P0 and P3-P2.
// Each input transfer gives exactly one output transfer with the point truncated toward
// zero to whole pixels, saturated to 14-bit two's complement, and a flag that is set
// when the unsaturated point lies inside the window set by the two registers
// (index 0: width, index 1: height, both reset to 700; other indexes are ignored).
// Throughput is one item per clock while out_stall is low; the pipeline has seven stages:
// input register, t squared, t cubed, coefficient products, sum, truncation
// and the output register. Each stage holds its item only when the stage after it is
// full and held, so bubbles close up and new items are taken while a result waits.
// The configuration port is always ready; write it only while the block is idle, as
// items in flight are judged against the window in force when they reach the output.
module hermite_curve_point_eval_unit #(
	parameter int T_FRAC_BITS = 16,
	parameter int COORD_BITS  = 12
) (
	input  logic                                      clk,
	input  logic                                      arst_n,

	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  logic [COORD_BITS-1:0]                     p0_x,
	input  logic [COORD_BITS-1:0]                     p0_y,
	input  logic [COORD_BITS-1:0]                     p1_x,
	input  logic [COORD_BITS-1:0]                     p1_y,
	input  logic [COORD_BITS-1:0]                     p2_x,
	input  logic [COORD_BITS-1:0]                     p2_y,
	input  logic [COORD_BITS-1:0]                     p3_x,
	input  logic [COORD_BITS-1:0]                     p3_y,
	input  logic [T_FRAC_BITS:0]                      t_fraction,

	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic signed [hcpe_pkg::OUT_BITS-1:0]      pixel_x,
	output logic signed [hcpe_pkg::OUT_BITS-1:0]      pixel_y,
	output logic                                      in_window,

	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [hcpe_pkg::CFG_IDX_BITS-1:0]         cfg_index,
	input  logic [hcpe_pkg::WIN_BITS-1:0]             cfg_data
);

	localparam int NS      = hcpe_pkg::NUM_STAGES;
	localparam int COORD_W = COORD_BITS + 7;

	// stage occupancy and the ready chain that runs back from the output
	logic [NS:1]   vld_q;
	logic [NS+1:1] rdy;
	hcpe_pkg::pipe_en_t en;

	logic [hcpe_pkg::WIN_BITS-1:0] win_width_q, win_height_q;

	logic [T_FRAC_BITS:0]         a_s3, t2_s3, t3_s3;
	logic signed [COORD_W-1:0]    x_s6, y_s6;

	always_comb begin
		rdy[NS+1] = !out_stall;
		for (int k = NS; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign en = '{s1: rdy[1], s2: rdy[2], s3: rdy[3], s4: rdy[4],
		s5: rdy[5], s6: rdy[6], s7: rdy[7]};

	assign in_stall  = !rdy[1];
	assign out_valid = vld_q[NS];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) vld_q[1] <= in_valid;
			for (int k = 2; k <= NS; k++) begin
				if (rdy[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_width_q  <= hcpe_pkg::WIN_RESET;
			win_height_q <= hcpe_pkg::WIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == hcpe_pkg::REG_WIDTH)  win_width_q  <= cfg_data;
			if (cfg_index == hcpe_pkg::REG_HEIGHT) win_height_q <= cfg_data;
		end
	end

	// powers of t, shared by both lanes
	hcpe_power #(.T_FRAC_BITS(T_FRAC_BITS)) u_power (
		.clk        (clk),
		.en         (en),
		.t_fraction (t_fraction),
		.a_s3       (a_s3),
		.t2_s3      (t2_s3),
		.t3_s3      (t3_s3)
	);

	// x lane
	hcpe_lane #(.T_FRAC_BITS(T_FRAC_BITS), .COORD_BITS(COORD_BITS)) u_lane_x (
		.clk      (clk),
		.en       (en),
		.q0       (p0_x),
		.q1       (p1_x),
		.q2       (p2_x),
		.q3       (p3_x),
		.a_s3     (a_s3),
		.t2_s3    (t2_s3),
		.t3_s3    (t3_s3),
		.coord_s6 (x_s6)
	);

	// y lane
	hcpe_lane #(.T_FRAC_BITS(T_FRAC_BITS), .COORD_BITS(COORD_BITS)) u_lane_y (
		.clk      (clk),
		.en       (en),
		.q0       (p0_y),
		.q1       (p1_y),
		.q2       (p2_y),
		.q3       (p3_y),
		.a_s3     (a_s3),
		.t2_s3    (t2_s3),
		.t3_s3    (t3_s3),
		.coord_s6 (y_s6)
	);

	// saturation and window test
	hcpe_merge #(.COORD_W(COORD_W)) u_merge (
		.clk        (clk),
		.en         (en),
		.x_s6       (x_s6),
		.y_s6       (y_s6),
		.win_width  (win_width_q),
		.win_height (win_height_q),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.in_window  (in_window)
	);

	// input held back only when every stage is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (&vld_q))
		else $error("input stalled with a free stage");

	// items in flight change only by transfers at the two ends
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ($countones(vld_q) == $past($countones(vld_q))
			+ $past(int'(in_valid && !in_stall)) - $past(int'(out_valid && !out_stall))))
		else $error("item lost or invented in pipeline");

	// a held output keeps its stage from loading, and the input is held exactly when every stage is full
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> (!en.s7 && !rdy[1] == (&vld_q)))
		else $error("output stage loaded while held");

	// a width write lands in its register
	a_cfg_width: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == hcpe_pkg::REG_WIDTH)
		|=> (win_width_q == $past(cfg_data)))
		else $error("window width write lost");

endmodule
